FILE: design/vr_pkg.sv
// ----------------------------------------------------------------------------
// vr_pkg
// Shared types, field widths and width helpers for the refraction pipeline.
// ----------------------------------------------------------------------------
package vr_pkg;

  localparam int FRAC_BITS_DEF = 15;
  localparam int VEC_W         = 18;
  localparam int ETA_W         = 16;
  localparam int SAT_W         = 64;

  localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

  typedef logic signed [VEC_W-1:0] vec_t;

  typedef struct packed {
    vec_t perp_x;
    vec_t perp_y;
    vec_t perp_z;
    vec_t norm_x;
    vec_t norm_y;
    vec_t norm_z;
  } side_t;

  // width of the dot product / |perp|^2 datapath at 2F fraction bits
  function automatic int wide_w(input int f);
    return (2 * f + 2 > 39) ? 2 * f + 2 : 39;
  endfunction

  // width of the square root operand, rounded up to an even count
  function automatic int x_w(input int f);
    int w;
    w = wide_w(f) - 1;
    return w + (w & 1);
  endfunction

  function automatic vec_t sat_vec(input logic signed [SAT_W-1:0] v);
    vec_t r;
    if (v > SAT_W'(VEC_MAX)) begin
      r = VEC_MAX;
    end else if (v < SAT_W'(VEC_MIN)) begin
      r = VEC_MIN;
    end else begin
      r = v[VEC_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/vr_perp.sv
// ----------------------------------------------------------------------------
// vr_perp
// Eight-stage front end: cosine, perpendicular part and |1 - |perp|^2|.
// ----------------------------------------------------------------------------
module vr_perp #(
  parameter int FRAC_BITS = vr_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  vr_pkg::vec_t                         dir_x,
  input  vr_pkg::vec_t                         dir_y,
  input  vr_pkg::vec_t                         dir_z,
  input  vr_pkg::vec_t                         norm_x,
  input  vr_pkg::vec_t                         norm_y,
  input  vr_pkg::vec_t                         norm_z,
  input  logic [vr_pkg::ETA_W-1:0]             eta,
  output logic                                 out_valid,
  output logic [vr_pkg::x_w(FRAC_BITS)-1:0]    diff_abs,
  output vr_pkg::side_t                        side
);

  localparam int VW    = vr_pkg::VEC_W;
  localparam int EW    = vr_pkg::ETA_W;
  localparam int DN_W  = 2 * VW;
  localparam int C_W   = vr_pkg::wide_w(FRAC_BITS);
  localparam int RC_W  = C_W + 1;
  localparam int COS_W = C_W + 1 - FRAC_BITS;
  localparam int PW    = COS_W + VW;
  localparam int PR_W  = PW + 1 - FRAC_BITS;
  localparam int U_W   = ((PR_W > VW) ? PR_W : VW) + 1;
  localparam int E_W   = U_W + EW + 1;
  localparam int ER_W  = E_W - FRAC_BITS + 2;
  localparam int X_W   = vr_pkg::x_w(FRAC_BITS);

  localparam logic signed [C_W-1:0] ONE2 =
    {{(C_W-2*FRAC_BITS-1){1'b0}}, 1'b1, {(2*FRAC_BITS){1'b0}}};
  localparam logic signed [RC_W-1:0] HALF_C = RC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW:0]     HALF_P = (PW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [E_W:0]    HALF_E = (E_W + 1)'(1) << (FRAC_BITS - 2);

  vr_pkg::vec_t d_in [3];
  vr_pkg::vec_t n_in [3];

  assign d_in[0] = dir_x;
  assign d_in[1] = dir_y;
  assign d_in[2] = dir_z;
  assign n_in[0] = norm_x;
  assign n_in[1] = norm_y;
  assign n_in[2] = norm_z;

  logic [7:0] v_r;

  logic signed [DN_W-1:0] dn1_r [3];
  vr_pkg::vec_t           d1_r [3], d2_r [3], d3_r [3];
  vr_pkg::vec_t           n1_r [3], n2_r [3], n3_r [3], n4_r [3], n5_r [3];
  vr_pkg::vec_t           n6_r [3], n7_r [3];
  logic [EW-1:0]          eta1_r, eta2_r, eta3_r, eta4_r;
  logic signed [COS_W-1:0] cos2_r;
  logic signed [PW-1:0]   cn3_r [3];
  logic signed [U_W-1:0]  u4_r [3];
  logic signed [E_W-1:0]  eu5_r [3];
  vr_pkg::vec_t           perp6_r [3], perp7_r [3], perp8_r [3];
  logic signed [DN_W-1:0] sq7_r [3];
  vr_pkg::vec_t           n8_r [3];
  logic [X_W-1:0]         diff8_r;

  // stage 2: clamp and round the cosine
  logic signed [C_W-1:0]   dsum, c2, c2c;
  logic signed [RC_W-1:0]  crnd;
  logic signed [COS_W-1:0] cos_nxt;

  assign dsum    = C_W'(dn1_r[0]) + C_W'(dn1_r[1]) + C_W'(dn1_r[2]);
  assign c2      = -dsum;
  assign c2c     = (c2 > ONE2) ? ONE2 : c2;
  assign crnd    = RC_W'(c2c) + HALF_C;
  assign cos_nxt = crnd[C_W:FRAC_BITS];

  // stages 4 and 6: rounding of cos*n and eta*u
  logic signed [PW:0]     cn_sum [3];
  logic signed [PR_W-1:0] cn_rnd [3];
  logic signed [U_W-1:0]  u_nxt [3];
  logic signed [E_W:0]    eu_sum [3];
  logic signed [ER_W-1:0] eu_rnd [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cn_sum[i] = (PW + 1)'(cn3_r[i]) + HALF_P;
      cn_rnd[i] = cn_sum[i][PW:FRAC_BITS];
      u_nxt[i]  = U_W'(cn_rnd[i]) + U_W'(d3_r[i]);
      eu_sum[i] = (E_W + 1)'(eu5_r[i]) + HALF_E;
      eu_rnd[i] = eu_sum[i][E_W:FRAC_BITS-1];
    end
  end

  // stage 8: |1 - |perp|^2|
  logic signed [C_W-1:0] mag2, diff, absd;

  assign mag2 = C_W'(sq7_r[0]) + C_W'(sq7_r[1]) + C_W'(sq7_r[2]);
  assign diff = ONE2 - mag2;
  assign absd = diff[C_W-1] ? -diff : diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dn1_r[i]   <= DN_W'(d_in[i]) * DN_W'(n_in[i]);
      d1_r[i]    <= d_in[i];
      n1_r[i]    <= n_in[i];
      d2_r[i]    <= d1_r[i];
      n2_r[i]    <= n1_r[i];
      cn3_r[i]   <= PW'(cos2_r) * PW'(n2_r[i]);
      d3_r[i]    <= d2_r[i];
      n3_r[i]    <= n2_r[i];
      u4_r[i]    <= u_nxt[i];
      n4_r[i]    <= n3_r[i];
      eu5_r[i]   <= E_W'($signed({1'b0, eta4_r})) * E_W'(u4_r[i]);
      n5_r[i]    <= n4_r[i];
      perp6_r[i] <= vr_pkg::sat_vec(vr_pkg::SAT_W'(eu_rnd[i]));
      n6_r[i]    <= n5_r[i];
      sq7_r[i]   <= DN_W'(perp6_r[i]) * DN_W'(perp6_r[i]);
      perp7_r[i] <= perp6_r[i];
      n7_r[i]    <= n6_r[i];
      perp8_r[i] <= perp7_r[i];
      n8_r[i]    <= n7_r[i];
    end
    eta1_r  <= eta;
    eta2_r  <= eta1_r;
    eta3_r  <= eta2_r;
    eta4_r  <= eta3_r;
    cos2_r  <= cos_nxt;
    diff8_r <= X_W'($unsigned(absd));
  end

  assign out_valid   = v_r[7];
  assign diff_abs    = diff8_r;
  assign side.perp_x = perp8_r[0];
  assign side.perp_y = perp8_r[1];
  assign side.perp_z = perp8_r[2];
  assign side.norm_x = n8_r[0];
  assign side.norm_y = n8_r[1];
  assign side.norm_z = n8_r[2];

endmodule

FILE: design/vr_sqrt.sv
// ----------------------------------------------------------------------------
// vr_sqrt
// Pipelined floor square root, one root bit per stage, with side data.
// ----------------------------------------------------------------------------
module vr_sqrt #(
  parameter int X_W    = vr_pkg::x_w(vr_pkg::FRAC_BITS_DEF),
  parameter int DATA_W = $bits(vr_pkg::side_t)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [X_W-1:0]      x_in,
  input  logic [DATA_W-1:0]   data_in,
  output logic                out_valid,
  output logic [X_W/2-1:0]    root,
  output logic [DATA_W-1:0]   data_out
);

  localparam int K = X_W / 2;

  logic [K:0]        rem_r  [K];
  logic [K-1:0]      root_r [K];
  logic [X_W-1:0]    x_r    [K-1];
  logic [DATA_W-1:0] dat_r  [K];
  logic [K-1:0]      v_r;

  for (genvar j = 0; j < K; j++) begin : g_stage
    logic [K:0]        rem_i;
    logic [K-1:0]      root_i;
    logic [X_W-1:0]    x_i;
    logic [DATA_W-1:0] dat_i;
    logic              v_i;
    logic [K+2:0]      tmp, trial, sub;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign x_i    = x_in;
      assign dat_i  = data_in;
      assign v_i    = in_valid;
    end else begin : g_next
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
      assign x_i    = x_r[j-1];
      assign dat_i  = dat_r[j-1];
      assign v_i    = v_r[j-1];
    end

    assign tmp   = {rem_i, x_i[X_W-1:X_W-2]};
    assign trial = {1'b0, root_i, 2'b01};
    assign ge    = (tmp >= trial);
    assign sub   = tmp - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= ge ? sub[K:0] : tmp[K:0];
      root_r[j] <= {root_i[K-2:0], ge};
      dat_r[j]  <= dat_i;
    end

    if (j < K - 1) begin : g_shift
      always_ff @(posedge clk) begin
        x_r[j] <= {x_i[X_W-3:0], 2'b00};
      end
    end
  end

  assign out_valid = v_r[K-1];
  assign root      = root_r[K-1];
  assign data_out  = dat_r[K-1];

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[K-1] |-> ({1'b0, rem_r[K-1]} <= {1'b0, root_r[K-1], 1'b0}))
    else $error("square root remainder exceeds twice the root");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[K-1] |-> $past(in_valid, K))
    else $error("square root result without a matching item");

endmodule

FILE: design/vr_combine.sv
// ----------------------------------------------------------------------------
// vr_combine
// Two-stage back end: parallel part from the root, sum and saturation.
// ----------------------------------------------------------------------------
module vr_combine #(
  parameter int FRAC_BITS = vr_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic [vr_pkg::x_w(FRAC_BITS)/2-1:0]   root,
  input  vr_pkg::side_t                         side,
  output logic                                  out_valid,
  output vr_pkg::vec_t                          res_x,
  output vr_pkg::vec_t                          res_y,
  output vr_pkg::vec_t                          res_z
);

  localparam int VW   = vr_pkg::VEC_W;
  localparam int K    = vr_pkg::x_w(FRAC_BITS) / 2;
  localparam int R_W  = K + 1 + VW;
  localparam int RR_W = R_W + 1 - FRAC_BITS;
  localparam int S_W  = ((RR_W > VW) ? RR_W : VW) + 1;

  localparam logic signed [R_W:0] HALF_R = (R_W + 1)'(1) << (FRAC_BITS - 1);

  vr_pkg::vec_t n_in [3];
  vr_pkg::vec_t p_in [3];

  assign n_in[0] = side.norm_x;
  assign n_in[1] = side.norm_y;
  assign n_in[2] = side.norm_z;
  assign p_in[0] = side.perp_x;
  assign p_in[1] = side.perp_y;
  assign p_in[2] = side.perp_z;

  logic                  va_r, vb_r;
  logic signed [R_W-1:0] pr_r   [3];
  vr_pkg::vec_t          perp_r [3];
  vr_pkg::vec_t          res_r  [3];

  logic signed [R_W:0]    pr_sum [3];
  logic signed [RR_W-1:0] pr_rnd [3];
  logic signed [S_W-1:0]  s      [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr_sum[i] = (R_W + 1)'(pr_r[i]) + HALF_R;
      pr_rnd[i] = pr_sum[i][R_W:FRAC_BITS];
      s[i]      = S_W'(perp_r[i]) - S_W'(pr_rnd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pr_r[i]   <= R_W'($signed({1'b0, root})) * R_W'(n_in[i]);
      perp_r[i] <= p_in[i];
      res_r[i]  <= vr_pkg::sat_vec(vr_pkg::SAT_W'(s[i]));
    end
  end

  assign out_valid = vb_r;
  assign res_x     = res_r[0];
  assign res_y     = res_r[1];
  assign res_z     = res_r[2];

endmodule

FILE: design/vector_refraction_top.sv
// ----------------------------------------------------------------------------
// vector_refraction_top
// Snell refraction of a unit direction about a unit normal, fixed point.
//
// A fully pipelined unit: one item may be started in every cycle and busy
// stays low. Each result appears on out_x/y/z for one cycle with out_valid
// high. K = x_w(FRAC_BITS)/2 is the number of square root stages (K = 19
// at 15 fraction bits). The depth is set by the square root, which resolves
// one root bit per stage. The receiver cannot stall; results must be taken
// as they come.
// ----------------------------------------------------------------------------
module vector_refraction_top #(
  parameter int FRAC_BITS = vr_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  vr_pkg::vec_t             in_dir_x,
  input  vr_pkg::vec_t             in_dir_y,
  input  vr_pkg::vec_t             in_dir_z,
  input  vr_pkg::vec_t             in_norm_x,
  input  vr_pkg::vec_t             in_norm_y,
  input  vr_pkg::vec_t             in_norm_z,
  input  logic [vr_pkg::ETA_W-1:0] in_index_ratio,
  output logic                     out_valid,
  output vr_pkg::vec_t             out_x,
  output vr_pkg::vec_t             out_y,
  output vr_pkg::vec_t             out_z
);

  localparam int X_W = vr_pkg::x_w(FRAC_BITS);
  localparam int K   = X_W / 2;
  localparam int LAT = 8 + K + 2;

  logic                 front_valid, root_valid;
  logic [X_W-1:0]       diff_abs;
  logic [K-1:0]         root;
  vr_pkg::side_t        front_side, root_side;

  assign busy = 1'b0;

  vr_perp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_perp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .dir_x     (in_dir_x),
    .dir_y     (in_dir_y),
    .dir_z     (in_dir_z),
    .norm_x    (in_norm_x),
    .norm_y    (in_norm_y),
    .norm_z    (in_norm_z),
    .eta       (in_index_ratio),
    .out_valid (front_valid),
    .diff_abs  (diff_abs),
    .side      (front_side)
  );

  vr_sqrt #(
    .X_W    (X_W),
    .DATA_W ($bits(vr_pkg::side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .x_in      (diff_abs),
    .data_in   (front_side),
    .out_valid (root_valid),
    .root      (root),
    .data_out  (root_side)
  );

  vr_combine #(
    .FRAC_BITS (FRAC_BITS)
  ) u_combine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (root_valid),
    .root      (root),
    .side      (root_side),
    .out_valid (out_valid),
    .res_x     (out_x),
    .res_y     (out_y),
    .res_z     (out_z)
  );

  a_out_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a started item");

  a_start_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("started item produced no result");

endmodule
